// ----- design/nsc_pkg.sv -----
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types and constants for the Annex B start code parser.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam int REGION_MAX = 188;

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] TYPE_MASK = 8'h1F;

    localparam logic [4:0] TYPE_NON_IDR    = 5'd1;
    localparam logic [4:0] TYPE_IDR        = 5'd5;
    localparam logic [4:0] TYPE_SVC_PREFIX = 5'd14;
    localparam logic [4:0] TYPE_SVC_SLICE  = 5'd20;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PREFIX = 3'd1,
        PH_HEADER = 3'd2,
        PH_BODY   = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_CODE   = 2'd1,
        ST_NO_HEADER = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SC_OTHER  = 2'd0,
        SC_IDR    = 2'd1,
        SC_NONIDR = 2'd2
    } slice_class_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  zero_run;
        logic [2:0]  prefix_count;
        logic [7:0]  body_count;
        logic [4:0]  held_type;
        logic [2:0]  held_prefix_len;
    } parse_state_t;

    typedef struct packed {
        status_t      status;
        logic [2:0]   start_code_len;
        logic [7:0]   nal_length;
        logic [4:0]   unit_type;
        logic         type_valid;
        slice_class_t slice_class;
        logic         ended_by_code;
    } nal_result_t;

endpackage

// ----- design/nsc_step.sv -----
// ----------------------------------------------------------------------------
// nsc_step
// Next parse state and optional result for one incoming byte.
// ----------------------------------------------------------------------------
module nsc_step
    import nsc_pkg::*;
(
    input  parse_state_t state,
    input  logic [7:0]   data_byte,
    input  logic         first_byte,
    input  logic         last_byte,
    output parse_state_t state_next,
    output logic         emit,
    output nal_result_t  result
);

    parse_state_t s;
    logic [8:0]   span;
    logic         with_type;
    logic [4:0]   t;

    always_comb
    begin
        s = state;
        if (first_byte)
        begin
            s = '0;
            s.phase = PH_PREFIX;
        end

        state_next = s;
        emit       = 1'b0;
        with_type  = 1'b0;
        result     = '0;
        span       = '0;

        case (s.phase)
            PH_PREFIX:
            begin
                if (s.prefix_count < 3'd2)
                begin
                    if (data_byte != BYTE_ZERO)
                    begin
                        emit = 1'b1;
                    end
                end
                else if (s.prefix_count == 3'd2)
                begin
                    if (data_byte == BYTE_ONE)
                    begin
                        state_next.held_prefix_len = 3'd3;
                    end
                    else if (data_byte != BYTE_ZERO)
                    begin
                        emit = 1'b1;
                    end
                end
                else
                begin
                    if (data_byte != BYTE_ONE)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        state_next.held_prefix_len = 3'd4;
                    end
                end
                if (emit)
                begin
                    result.status = ST_NO_CODE;
                end
                else
                begin
                    state_next.prefix_count = s.prefix_count + 3'd1;
                    if (state_next.held_prefix_len != 3'd0)
                    begin
                        state_next.phase = PH_HEADER;
                        if (last_byte)
                        begin
                            emit                  = 1'b1;
                            result.status         = ST_NO_HEADER;
                            result.start_code_len = state_next.held_prefix_len;
                        end
                    end
                    else if (last_byte)
                    begin
                        emit          = 1'b1;
                        result.status = ST_NO_CODE;
                    end
                end
            end
            PH_HEADER:
            begin
                state_next.held_type  = 5'(data_byte & TYPE_MASK);
                state_next.body_count = 8'd1;
                state_next.zero_run   = (data_byte == BYTE_ZERO) ? 2'd1 : 2'd0;
                state_next.phase      = PH_BODY;
                span = {6'd0, s.held_prefix_len} + 9'd1;
                if (last_byte || (span >= 9'(REGION_MAX)))
                begin
                    emit              = 1'b1;
                    with_type         = 1'b1;
                    result.nal_length = 8'd1;
                end
            end
            PH_BODY:
            begin
                if ((data_byte == BYTE_ONE) && (s.zero_run >= 2'd2) &&
                    (((s.zero_run == 2'd3) && (s.body_count >= 8'd4)) ||
                     (s.body_count >= 8'd3)))
                begin
                    emit                 = 1'b1;
                    with_type            = 1'b1;
                    result.ended_by_code = 1'b1;
                    if ((s.zero_run == 2'd3) && (s.body_count >= 8'd4))
                    begin
                        result.nal_length = s.body_count - 8'd3;
                    end
                    else
                    begin
                        result.nal_length = s.body_count - 8'd2;
                    end
                end
                else
                begin
                    if (data_byte == BYTE_ZERO)
                    begin
                        if (s.zero_run != 2'd3)
                        begin
                            state_next.zero_run = s.zero_run + 2'd1;
                        end
                    end
                    else
                    begin
                        state_next.zero_run = 2'd0;
                    end
                    if (s.body_count != 8'hFF)
                    begin
                        state_next.body_count = s.body_count + 8'd1;
                    end
                    span = {6'd0, s.held_prefix_len} + {1'b0, state_next.body_count};
                    if (last_byte || (span >= 9'(REGION_MAX)))
                    begin
                        emit              = 1'b1;
                        with_type         = 1'b1;
                        result.nal_length = state_next.body_count;
                    end
                end
            end
            default:
            begin
                state_next = s;
            end
        endcase

        t = state_next.held_type;
        if (with_type)
        begin
            result.status         = ST_OK;
            result.start_code_len = s.held_prefix_len;
            result.unit_type      = t;
            result.type_valid     = !(t inside {TYPE_SVC_PREFIX, TYPE_SVC_SLICE});
            if (t == TYPE_IDR)
            begin
                result.slice_class = SC_IDR;
            end
            else if (t == TYPE_NON_IDR)
            begin
                result.slice_class = SC_NONIDR;
            end
            else
            begin
                result.slice_class = SC_OTHER;
            end
        end

        if (emit)
        begin
            state_next.phase = PH_DONE;
        end
    end

endmodule

// ----- design/h264_nal_start_code_parser_top.sv -----
// ----------------------------------------------------------------------------
// h264_nal_start_code_parser_top
// Annex B start code check and NAL header parse, one result per region.
// ----------------------------------------------------------------------------
// Bytes of a payload region are taken one per cycle. Each byte passes through
// a single level of parse logic into the result register, so a result is
// shown in the cycle after the byte that completes it, and a new byte can be
// transferred in every cycle while the result register is empty or being
// taken. Only a held result that is not taken stops the input.
module h264_nal_start_code_parser_top
    import nsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [2:0] start_code_len,
    output logic [7:0] nal_length,
    output logic [4:0] unit_type,
    output logic       type_valid,
    output logic [1:0] slice_class,
    output logic       ended_by_code
);

    parse_state_t state_reg;
    parse_state_t state_next;
    nal_result_t  result_reg;
    nal_result_t  result_next;
    logic         out_valid_reg;
    logic         emit;
    logic         in_fire;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    nsc_step u_step
    (
        .state      (state_reg),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .state_next (state_next),
        .emit       (emit),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
            end
            if (in_fire && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = result_reg.status;
    assign start_code_len = result_reg.start_code_len;
    assign nal_length     = result_reg.nal_length;
    assign unit_type      = result_reg.unit_type;
    assign type_valid     = result_reg.type_valid;
    assign slice_class    = result_reg.slice_class;
    assign ended_by_code  = result_reg.ended_by_code;

endmodule

// ----- design/nsc_checker.sv -----
// ----------------------------------------------------------------------------
// nsc_checker
// Port-level checks on the results of the start code parser.
// ----------------------------------------------------------------------------
module nsc_checker
    import nsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [2:0] start_code_len,
    input logic [7:0] nal_length,
    input logic [4:0] unit_type,
    input logic       type_valid,
    input logic [1:0] slice_class
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(nal_length) && $stable(status))
        else $error("Result changed before its transfer.");

    a_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NO_CODE) |->
            (start_code_len == 3'd0) && (nal_length == 8'd0) && !type_valid)
        else $error("A missing start code carries result fields.");

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |->
            ((start_code_len == 3'd3) || (start_code_len == 3'd4)) &&
            (nal_length != 8'd0))
        else $error("A good result has a bad start code length or zero length.");

    a_type_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((slice_class == SC_IDR) || type_valid) |->
            (status == ST_OK) && (unit_type != TYPE_SVC_PREFIX) &&
            (unit_type != TYPE_SVC_SLICE) &&
            ((slice_class != SC_IDR) || (unit_type == TYPE_IDR)))
        else $error("Type validity or slice class disagrees with the NAL type.");

endmodule

bind h264_nal_start_code_parser_top nsc_checker u_nsc_checker (.*);
